[hdl/fdsp_pkg.sv]
// ---------------------------------------------------------------------------
// fdsp_pkg
// Shared types, character codes and constants for the framed decimal
// setpoint parser.
// ---------------------------------------------------------------------------
package fdsp_pkg;

    localparam int FRAC_DIGITS = 6;

    localparam int BYTE_W  = 8;
    localparam int CNT_W   = 4;
    localparam int FRAC_W  = 3;
    localparam int MAG_W   = 60;
    localparam int VALUE_W = 61;
    localparam int SUM_W   = 64;
    localparam int POW_W   = 20;
    localparam int TERM_W  = 24;

    localparam logic [MAG_W-1:0]  LIMIT_MAG        = 60'd999999999999999999;
    localparam logic [CNT_W-1:0]  MAX_LENGTH_RESET = 4'd10;
    localparam logic [FRAC_W-1:0] FRAC_LIMIT       = FRAC_W'(FRAC_DIGITS);

    localparam logic [BYTE_W-1:0] CHAR_START   = 8'h56;
    localparam logic [BYTE_W-1:0] CHAR_NEWLINE = 8'h0A;
    localparam logic [BYTE_W-1:0] CHAR_MINUS   = 8'h2D;
    localparam logic [BYTE_W-1:0] CHAR_POINT   = 8'h2E;
    localparam logic [BYTE_W-1:0] CHAR_ZERO    = 8'h30;
    localparam logic [BYTE_W-1:0] CHAR_NINE    = 8'h39;
    localparam logic [BYTE_W-1:0] CHAR_NUL     = 8'h00;

    typedef struct packed {
        logic                in_frame;
        logic [CNT_W-1:0]    char_count;
        logic                is_negative;
        logic                fraction_mode;
        logic [FRAC_W-1:0]   fraction_digits_seen;
        logic                text_ended;
        logic [MAG_W-1:0]    accumulated_value;
    } t_frame_state;

    localparam t_frame_state FRAME_CLEAR = '0;

    // weight of one digit, 10^idx
    function automatic logic [POW_W-1:0] pow10(input logic [FRAC_W-1:0] idx);
        logic [POW_W-1:0] p;
        case (idx)
            3'd0:    p = 20'd1;
            3'd1:    p = 20'd10;
            3'd2:    p = 20'd100;
            3'd3:    p = 20'd1000;
            3'd4:    p = 20'd10000;
            3'd5:    p = 20'd100000;
            3'd6:    p = 20'd1000000;
            default: p = 20'd1;
        endcase
        return p;
    endfunction

endpackage

[hdl/fdsp_update.sv]
// ---------------------------------------------------------------------------
// fdsp_update
// Per-byte frame and number update: takes the frame state and one byte,
// gives the next state and, on a closing newline, the signed result.
// ---------------------------------------------------------------------------
module fdsp_update
    import fdsp_pkg::*;
(
    input  t_frame_state            i_state,
    input  logic [BYTE_W-1:0]       i_byte,
    input  logic [CNT_W-1:0]        i_max_length,
    output t_frame_state            o_state,
    output logic                    o_emit,
    output logic [VALUE_W-1:0]      o_value
);

    logic [3:0]          digit;
    logic                is_digit;
    logic [SUM_W-1:0]    acc_ext;
    logic [TERM_W-1:0]   int_term;
    logic [SUM_W-1:0]    int_sum;
    logic [MAG_W-1:0]    int_sat;
    logic [FRAC_W-1:0]   frac_seen_next;
    logic [TERM_W-1:0]   frac_term;
    logic [SUM_W-1:0]    frac_sum;
    logic [MAG_W-1:0]    frac_sat;
    logic                too_long;
    logic                first;
    logic [VALUE_W-1:0]  mag_ext;

    assign digit          = i_byte[3:0];
    assign is_digit       = (i_byte inside {[CHAR_ZERO:CHAR_NINE]});
    assign acc_ext        = SUM_W'(i_state.accumulated_value);

    // integer digit: acc * 10 + d * 10^FRAC_DIGITS
    assign int_term       = TERM_W'(digit) * TERM_W'(pow10(FRAC_LIMIT));
    assign int_sum        = (acc_ext << 3) + (acc_ext << 1) + SUM_W'(int_term);
    assign int_sat        = (int_sum > SUM_W'(LIMIT_MAG)) ? LIMIT_MAG : int_sum[MAG_W-1:0];

    // fraction digit weighted by its place
    assign frac_seen_next = i_state.fraction_digits_seen + FRAC_W'(1);
    assign frac_term      = TERM_W'(digit) * TERM_W'(pow10(FRAC_LIMIT - frac_seen_next));
    assign frac_sum       = acc_ext + SUM_W'(frac_term);
    assign frac_sat       = (frac_sum > SUM_W'(LIMIT_MAG)) ? LIMIT_MAG : frac_sum[MAG_W-1:0];

    assign too_long       = ({1'b0, i_state.char_count} + 5'd1) > {1'b0, i_max_length};
    assign first          = (i_state.char_count == '0);

    assign mag_ext        = VALUE_W'(i_state.accumulated_value);
    assign o_value        = i_state.is_negative ? (~mag_ext + VALUE_W'(1)) : mag_ext;

    always_comb begin
        o_state = i_state;
        o_emit  = 1'b0;
        if (!i_state.in_frame) begin
            if (i_byte == CHAR_START) begin
                o_state          = FRAME_CLEAR;
                o_state.in_frame = 1'b1;
            end
        end else if (i_byte == CHAR_START) begin
            o_state = i_state;
        end else if (i_byte == CHAR_NEWLINE) begin
            o_emit  = 1'b1;
            o_state = FRAME_CLEAR;
        end else if (too_long) begin
            o_state = FRAME_CLEAR;
        end else begin
            o_state.char_count = i_state.char_count + CNT_W'(1);
            if (!i_state.text_ended) begin
                if (i_byte == CHAR_NUL) begin
                    o_state.text_ended = 1'b1;
                end else if (first && i_byte == CHAR_MINUS) begin
                    o_state.is_negative = 1'b1;
                end else if (i_byte == CHAR_POINT) begin
                    o_state.fraction_mode = 1'b1;
                end else if (is_digit) begin
                    if (i_state.fraction_mode) begin
                        if (i_state.fraction_digits_seen < FRAC_LIMIT) begin
                            o_state.fraction_digits_seen = frac_seen_next;
                            o_state.accumulated_value    = frac_sat;
                        end
                    end else begin
                        o_state.accumulated_value = int_sat;
                    end
                end
            end
        end
    end

endmodule

[hdl/framed_decimal_setpoint_parser.sv]
// ---------------------------------------------------------------------------
// framed_decimal_setpoint_parser
// Parses 'V'-framed ASCII decimal setpoints into signed fixed point.
// ---------------------------------------------------------------------------
// Takes one received byte per cycle, back to back. A byte goes into an input
// register, the frame and number state is updated from it, and a closing
// newline loads the signed value (magnitude times 10^6, saturated at
// 999999999999999999) into the result register, which offers it. The input
// side only stalls when that result register is full and not being taken.
// max_length is written through its own channel, which is always ready; the
// user must write it only while idle, as the block does not enforce this.
module framed_decimal_setpoint_parser
    import fdsp_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,

    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CNT_W-1:0]     i_max_length,

    input  logic                 i_rx_valid,
    output logic                 o_rx_ready,
    input  logic [BYTE_W-1:0]    i_rx_byte,

    output logic                 o_setpoint_valid,
    input  logic                 i_setpoint_ready,
    output logic [VALUE_W-1:0]   o_setpoint_value
);

    logic                r_in_valid;
    logic [BYTE_W-1:0]   r_in_byte;
    logic [CNT_W-1:0]    r_max_length;
    t_frame_state        r_state;
    t_frame_state        n_state;
    logic                r_out_valid;
    logic [VALUE_W-1:0]  r_out_value;

    logic                stage_go;
    logic                emit;
    logic [VALUE_W-1:0]  value;

    fdsp_update u_update (
        .i_state      (r_state),
        .i_byte       (r_in_byte),
        .i_max_length (r_max_length),
        .o_state      (n_state),
        .o_emit       (emit),
        .o_value      (value)
    );

    assign stage_go         = r_in_valid && (!r_out_valid || i_setpoint_ready);
    assign o_rx_ready       = !r_in_valid || stage_go;
    assign o_cfg_ready      = 1'b1;
    assign o_setpoint_valid = r_out_valid;
    assign o_setpoint_value = r_out_value;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid   <= 1'b0;
            r_out_valid  <= 1'b0;
            r_state      <= FRAME_CLEAR;
            r_max_length <= MAX_LENGTH_RESET;
        end else begin
            if (o_rx_ready) begin
                r_in_valid <= i_rx_valid;
            end
            if (stage_go) begin
                r_state <= n_state;
            end
            if (stage_go && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_setpoint_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_valid) begin
                r_max_length <= i_max_length;
            end
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_rx_valid && o_rx_ready) begin
            r_in_byte <= i_rx_byte;
        end
        if (stage_go && emit) begin
            r_out_value <= value;
        end
    end

endmodule
